// File: rtl/ltgs_pkg.sv
// Shared constants, field widths and the configuration struct of the LDA topic sampler.
// Used by every module in rtl; depends on nothing else.
package ltgs_pkg;

  localparam int TOPICS = 64;
  localparam int DOCS   = 1024;
  localparam int VOCAB  = 4096;

  localparam int TOPIC_W     = $clog2(TOPICS);
  localparam int DOC_IDX_W   = $clog2(DOCS);
  localparam int WORD_IDX_W  = $clog2(VOCAB);
  localparam int DOC_ADDR_W  = TOPIC_W + DOC_IDX_W;
  localparam int WORD_ADDR_W = TOPIC_W + WORD_IDX_W;

  localparam int DOC_CNT_W  = 16;
  localparam int WORD_CNT_W = 24;
  localparam int TOT_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int PRIOR_W    = 24;
  localparam int VOCAB_W    = 13;
  localparam int NTOP_W     = 7;
  localparam int RND_W      = 32;

  localparam int A_W       = DOC_CNT_W + FRAC_W + 1;
  localparam int B_W       = WORD_CNT_W + FRAC_W + 1;
  localparam int PRIOR_P_W = VOCAB_W + PRIOR_W;
  localparam int D_W       = TOT_W + FRAC_W + 1;
  localparam int P_W       = A_W + B_W;
  localparam int WT_W      = 64;
  localparam int CNT_W     = $clog2(WT_W);

  localparam logic [1:0] KIND_ADD      = 2'd0;
  localparam logic [1:0] KIND_RESAMPLE = 2'd1;

  localparam logic [1:0] REG_TOPICS = 2'd0;
  localparam logic [1:0] REG_ALPHA  = 2'd1;
  localparam logic [1:0] REG_BETA   = 2'd2;
  localparam logic [1:0] REG_VOCAB  = 2'd3;

  typedef struct packed {
    logic [NTOP_W-1:0]  ntop;
    logic [PRIOR_W-1:0] alpha;
    logic [PRIOR_W-1:0] beta;
    logic [VOCAB_W-1:0] vocab;
  } cfg_t;

endpackage

// File: rtl/ltgs_cfg.sv
// APB-style configuration registers of the LDA topic sampler.
// Depends on ltgs_pkg for the register indexes and cfg_t.
module ltgs_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output ltgs_pkg::cfg_t cfg_o
);
  import ltgs_pkg::*;

  cfg_t        cfg_q;
  logic [1:0]  idx;

  assign idx    = paddr[3:2];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ntop  <= NTOP_W'(64);
      cfg_q.alpha <= PRIOR_W'(6554);
      cfg_q.beta  <= PRIOR_W'(655);
      cfg_q.vocab <= VOCAB_W'(4096);
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_TOPICS: cfg_q.ntop  <= pwdata[NTOP_W-1:0];
        REG_ALPHA:  cfg_q.alpha <= pwdata[PRIOR_W-1:0];
        REG_BETA:   cfg_q.beta  <= pwdata[PRIOR_W-1:0];
        REG_VOCAB:  cfg_q.vocab <= pwdata[VOCAB_W-1:0];
        default:    cfg_q       <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TOPICS: prdata = 32'(cfg_q.ntop);
      REG_ALPHA:  prdata = 32'(cfg_q.alpha);
      REG_BETA:   prdata = 32'(cfg_q.beta);
      REG_VOCAB:  prdata = 32'(cfg_q.vocab);
      default:    prdata = '0;
    endcase
  end

endmodule

// File: rtl/ltgs_wdiv.sv
// Shared weight unit: shift-add multiply of A by B, then restoring division by D.
// Depends on ltgs_pkg for the operand widths.
module ltgs_wdiv (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ltgs_pkg::A_W-1:0]  a_i,
  input  logic [ltgs_pkg::B_W-1:0]  b_i,
  input  logic [ltgs_pkg::D_W-1:0]  den_i,
  output logic                      done_o,
  output logic [ltgs_pkg::WT_W-1:0] quot_o
);
  import ltgs_pkg::*;

  typedef enum logic [1:0] {W_IDLE, W_MUL, W_PREP, W_DIV} wstate_e;

  wstate_e          state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [A_W-1:0]   mul_a_q;
  logic [P_W-1:0]   mcand_q;
  logic [P_W-1:0]   prod_q;
  logic [D_W-1:0]   den_q;
  logic [D_W-1:0]   rem_q;
  logic [WT_W-1:0]  quot_q;
  logic             done_q;

  logic [D_W:0]     trial;
  logic             ge;

  assign trial  = {rem_q, prod_q[WT_W-1]};
  assign ge     = trial >= {1'b0, den_q};
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= ((state_q == W_PREP) &&
                 (den_q == '0 || D_W'(prod_q[P_W-1:WT_W]) >= den_q)) ||
                ((state_q == W_DIV) && (cnt_q == CNT_W'(WT_W-1)));
      unique case (state_q)
        W_IDLE: begin
          if (start_i) begin
            mul_a_q <= a_i;
            mcand_q <= P_W'(b_i);
            prod_q  <= '0;
            den_q   <= den_i;
            cnt_q   <= '0;
            state_q <= W_MUL;
          end
        end
        W_MUL: begin
          if (mul_a_q[0]) prod_q <= prod_q + mcand_q;
          mcand_q <= {mcand_q[P_W-2:0], 1'b0};
          mul_a_q <= mul_a_q >> 1;
          cnt_q   <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(A_W-1)) state_q <= W_PREP;
        end
        W_PREP: begin
          // The high half of the product must stay below D, else the quotient overflows.
          cnt_q <= '0;
          if (den_q == '0) begin
            quot_q  <= '0;
            state_q <= W_IDLE;
          end else if (D_W'(prod_q[P_W-1:WT_W]) >= den_q) begin
            quot_q  <= '1;
            state_q <= W_IDLE;
          end else begin
            rem_q   <= D_W'(prod_q[P_W-1:WT_W]);
            quot_q  <= '0;
            state_q <= W_DIV;
          end
        end
        W_DIV: begin
          rem_q  <= ge ? D_W'(trial - {1'b0, den_q}) : trial[D_W-1:0];
          quot_q <= {quot_q[WT_W-2:0], ge};
          prod_q <= {prod_q[P_W-1:WT_W], prod_q[WT_W-2:0], 1'b0};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(WT_W-1)) begin
            state_q <= W_IDLE;
          end
        end
        default: state_q <= W_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/lda_gibbs_topic_sampler.sv
// Top level of the LDA collapsed Gibbs topic sampler: sequencer, count memories, draw.
// Depends on ltgs_pkg, ltgs_cfg and ltgs_wdiv.
//
//  channel  | direction | handshake                     | payload
//  s_axis   | in        | s_axis_tvalid_i/s_axis_tready_o | tuser kind, tdata token fields
//  m_axis   | out       | m_axis_tvalid_o/m_axis_tready_i | tdata topic and counts
//  apb      | in        | psel, penable, pready           | paddr, pwdata, prdata
//
// A resample is paced by the shared multiply-divide unit, which spends one cycle per
// bit and runs once for each topic in use, before the draw and the topic search.
// After reset a clearing pass over every word-memory address zeroes the count
// memories; no word is accepted meanwhile. A new word is accepted while a result waits.
module lda_gibbs_topic_sampler (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [63:0]  s_axis_tdata_i,  // document, word, current_topic, random_fraction
  input  logic [1:0]   s_axis_tuser_i,  // kind
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [79:0]  m_axis_tdata_o,  // new_topic, doc_topic_count, word_topic_count,
                                        // topic_total
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ltgs_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_UPD_RD, ST_UPD_WR, ST_SMP_RD, ST_SMP_GO, ST_SMP_WAIT,
    ST_MUL_HI, ST_MUL_LO, ST_DRAW, ST_SRCH_RD, ST_SRCH_CMP, ST_OUT_RD, ST_OUT_WAIT
  } state_e;

  cfg_t cfg;

  ltgs_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  state_e                 state_q;
  logic [WORD_ADDR_W-1:0] clr_q;
  logic [1:0]             kind_q;
  logic [DOC_IDX_W-1:0]   doc_q;
  logic [WORD_IDX_W-1:0]  word_q;
  logic [TOPIC_W-1:0]     tsel_q;
  logic [TOPIC_W-1:0]     ti_q;
  logic [TOPIC_W-1:0]     nlast_q;
  logic [RND_W-1:0]       rnd_q;
  logic                   dec_q;
  logic [PRIOR_P_W-1:0]   prior_q;
  logic [WT_W-1:0]        sum_q;
  logic [WT_W-1:0]        ph_q;
  logic [WT_W-1:0]        pl_q;
  logic [WT_W-1:0]        u_q;
  logic                   start_q;
  logic [A_W-1:0]         a_q;
  logic [B_W-1:0]         b_q;
  logic [D_W-1:0]         d_q;

  logic                   m_valid_q;
  logic [TOPIC_W-1:0]     o_topic_q;
  logic [DOC_CNT_W-1:0]   o_doc_q;
  logic [WORD_CNT_W-1:0]  o_word_q;
  logic [TOT_W-1:0]       o_tot_q;

  // Count memories and the cumulative weight store.
  logic [DOC_CNT_W-1:0]  doc_mem  [TOPICS*DOCS];
  logic [WORD_CNT_W-1:0] word_mem [TOPICS*VOCAB];
  logic [TOT_W-1:0]      tot_mem  [TOPICS];
  logic [WT_W-1:0]       cw_mem   [TOPICS];

  logic [DOC_CNT_W-1:0]  doc_rd_q;
  logic [WORD_CNT_W-1:0] word_rd_q;
  logic [TOT_W-1:0]      tot_rd_q;
  logic [WT_W-1:0]       cw_rd_q;

  logic [TOPIC_W-1:0]     asel;
  logic [DOC_ADDR_W-1:0]  doc_addr;
  logic [WORD_ADDR_W-1:0] word_addr;
  logic                   cnt_we;
  logic [DOC_ADDR_W-1:0]  doc_waddr;
  logic [WORD_ADDR_W-1:0] word_waddr;
  logic [TOPIC_W-1:0]     tot_waddr;
  logic [DOC_CNT_W-1:0]   doc_wdata;
  logic [WORD_CNT_W-1:0]  word_wdata;
  logic [TOT_W-1:0]       tot_wdata;
  logic                   cw_we;

  logic                   wu_done;
  logic [WT_W-1:0]        wu_quot;
  logic [WT_W:0]          sum_ext;
  logic [WT_W-1:0]        sum_d;
  logic [TOPIC_W-1:0]     nlast_d;
  logic                   accept;

  ltgs_wdiv u_wdiv (
    .clk_i, .rst_ni, .start_i(start_q), .a_i(a_q), .b_i(b_q), .den_i(d_q),
    .done_o(wu_done), .quot_o(wu_quot)
  );

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, o_tot_q, o_word_q, o_doc_q, o_topic_q};

  assign asel      = (state_q == ST_SMP_RD || state_q == ST_SMP_GO) ? ti_q : tsel_q;
  assign doc_addr  = {asel, doc_q};
  assign word_addr = {asel, word_q};

  assign sum_ext = {1'b0, sum_q} + {1'b0, wu_quot};
  assign sum_d   = sum_ext[WT_W] ? '1 : sum_ext[WT_W-1:0];
  assign cw_we   = (state_q == ST_SMP_WAIT) && wu_done;

  always_comb begin
    if (int'(cfg.ntop) == 0)           nlast_d = '0;
    else if (int'(cfg.ntop) > TOPICS)  nlast_d = TOPIC_W'(TOPICS - 1);
    else                               nlast_d = TOPIC_W'(int'(cfg.ntop) - 1);
  end

  // Write port: zeroes during the clearing pass, else the increment or decrement.
  always_comb begin
    cnt_we     = 1'b0;
    doc_waddr  = doc_addr;
    word_waddr = word_addr;
    tot_waddr  = tsel_q;
    doc_wdata  = '0;
    word_wdata = '0;
    tot_wdata  = '0;
    if (state_q == ST_CLEAR) begin
      cnt_we     = 1'b1;
      doc_waddr  = clr_q[DOC_ADDR_W-1:0];
      word_waddr = clr_q;
      tot_waddr  = clr_q[TOPIC_W-1:0];
    end else if (state_q == ST_UPD_WR) begin
      cnt_we = 1'b1;
      if (dec_q) begin
        doc_wdata  = (doc_rd_q == '0)  ? '0 : doc_rd_q - 1'b1;
        word_wdata = (word_rd_q == '0) ? '0 : word_rd_q - 1'b1;
        tot_wdata  = (tot_rd_q == '0)  ? '0 : tot_rd_q - 1'b1;
      end else begin
        doc_wdata  = (doc_rd_q == '1)  ? '1 : doc_rd_q + 1'b1;
        word_wdata = (word_rd_q == '1) ? '1 : word_rd_q + 1'b1;
        tot_wdata  = (tot_rd_q == '1)  ? '1 : tot_rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) doc_mem[doc_waddr] <= doc_wdata;
    doc_rd_q <= doc_mem[doc_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) word_mem[word_waddr] <= word_wdata;
    word_rd_q <= word_mem[word_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) tot_mem[tot_waddr] <= tot_wdata;
    tot_rd_q <= tot_mem[asel];
  end

  always_ff @(posedge clk_i) begin
    if (cw_we) cw_mem[ti_q] <= sum_d;
    cw_rd_q <= cw_mem[ti_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
      start_q   <= 1'b0;
    end else begin
      start_q <= (state_q == ST_SMP_GO);
      // The output wait state reloads the result register itself.
      if (m_valid_q && m_axis_tready_i && state_q != ST_OUT_WAIT) m_valid_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            doc_q   <= s_axis_tdata_i[DOC_IDX_W-1:0];
            word_q  <= s_axis_tdata_i[10 +: WORD_IDX_W];
            tsel_q  <= s_axis_tdata_i[22 +: TOPIC_W];
            rnd_q   <= s_axis_tdata_i[59:28];
            kind_q  <= s_axis_tuser_i;
            nlast_q <= nlast_d;
            prior_q <= PRIOR_P_W'(cfg.vocab) * PRIOR_P_W'(cfg.beta);
            dec_q   <= (s_axis_tuser_i == KIND_RESAMPLE);
            if (s_axis_tuser_i == KIND_ADD || s_axis_tuser_i == KIND_RESAMPLE) begin
              state_q <= ST_UPD_RD;
            end else begin
              state_q <= ST_OUT_RD;
            end
          end
        end
        ST_UPD_RD: state_q <= ST_UPD_WR;
        ST_UPD_WR: begin
          if (dec_q) begin
            ti_q    <= '0;
            sum_q   <= '0;
            state_q <= ST_SMP_RD;
          end else begin
            state_q <= ST_OUT_RD;
          end
        end
        ST_SMP_RD: state_q <= ST_SMP_GO;
        ST_SMP_GO: begin
          a_q     <= A_W'(cfg.alpha) + (A_W'(doc_rd_q) << FRAC_W);
          b_q     <= B_W'(cfg.beta) + (B_W'(word_rd_q) << FRAC_W);
          d_q     <= D_W'(prior_q) + (D_W'(tot_rd_q) << FRAC_W);
          state_q <= ST_SMP_WAIT;
        end
        ST_SMP_WAIT: begin
          if (wu_done) begin
            sum_q <= sum_d;
            if (ti_q == nlast_q) begin
              state_q <= ST_MUL_HI;
            end else begin
              ti_q    <= ti_q + 1'b1;
              state_q <= ST_SMP_RD;
            end
          end
        end
        ST_MUL_HI: begin
          ph_q    <= WT_W'(rnd_q) * WT_W'(sum_q[63:32]);
          state_q <= ST_MUL_LO;
        end
        ST_MUL_LO: begin
          pl_q    <= WT_W'(rnd_q) * WT_W'(sum_q[31:0]);
          state_q <= ST_DRAW;
        end
        ST_DRAW: begin
          u_q     <= ph_q + (pl_q >> 32);
          ti_q    <= '0;
          state_q <= ST_SRCH_RD;
        end
        ST_SRCH_RD: state_q <= ST_SRCH_CMP;
        ST_SRCH_CMP: begin
          // The last topic in use is taken when no weight lies above the draw.
          if (cw_rd_q > u_q || ti_q == nlast_q) begin
            tsel_q  <= ti_q;
            dec_q   <= 1'b0;
            state_q <= ST_UPD_RD;
          end else begin
            ti_q    <= ti_q + 1'b1;
            state_q <= ST_SRCH_RD;
          end
        end
        ST_OUT_RD: state_q <= ST_OUT_WAIT;
        ST_OUT_WAIT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            o_topic_q <= tsel_q;
            o_doc_q   <= doc_rd_q;
            o_word_q  <= word_rd_q;
            o_tot_q   <= tot_rd_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wu_done |-> state_q == ST_SMP_WAIT)
    else $error("weight unit finished outside the sampling wait");
  a_topic_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SMP_WAIT || state_q == ST_SRCH_CMP) |-> ti_q <= nlast_q)
    else $error("topic index beyond the topics in use");
  a_sum_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cw_we |-> sum_d >= sum_q)
    else $error("cumulative weight decreased");
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !s_axis_tready_o && !m_valid_q)
    else $error("stream active during the clearing pass");
`endif

endmodule

// File: verif/lda_gibbs_topic_sampler_tb.sv
// Self-checking testbench for lda_gibbs_topic_sampler: stream words in, results checked
// against a local count-table predictor. Depends on ltgs_pkg and the RTL top level.
module lda_gibbs_topic_sampler_tb;
  import ltgs_pkg::*;

  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_SPARE  = 2'd3;
  localparam int         CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  doc;
    logic [11:0] word;
    logic [5:0]  topic;
    logic [31:0] rnd;
  } token_t;

  typedef struct packed {
    logic [5:0]  topic;
    logic [15:0] doc_cnt;
    logic [23:0] word_cnt;
    logic [31:0] total;
  } counts_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;  // document, word, current_topic, random_fraction
  logic [1:0]  s_axis_tuser_i = '0;  // kind
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [79:0] m_axis_tdata_o;       // new_topic, doc_topic_count, word_topic_count,
                                     // topic_total
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lda_gibbs_topic_sampler dut (.*);

  always #5 clk_i = ~clk_i;

  // Local copy of the count tables and registers
  logic [31:0] topic_tot [TOPICS];
  logic [15:0] doc_cnt   [TOPICS*DOCS];
  logic [23:0] word_cnt  [TOPICS*VOCAB];
  logic [6:0]  ntop_r  = 7'd64;
  logic [23:0] alpha_r = 24'd6554;
  logic [23:0] beta_r  = 24'd655;
  logic [12:0] vocab_r = 13'd4096;

  token_t  pending_tokens [$];
  counts_t expected_counts [$];
  int      errors = 0;
  bit      quiet = 1'b0;
  int      send_gap = 0;
  int      recv_stall = 0;
  longint  cycles = 0;

  initial begin
    foreach (topic_tot[i]) topic_tot[i] = '0;
    foreach (doc_cnt[i]) doc_cnt[i] = '0;
    foreach (word_cnt[i]) word_cnt[i] = '0;
  end

  function automatic void add_tok(int t, int d, int w);
    if (topic_tot[t] != '1) topic_tot[t]++;
    if (doc_cnt[t*DOCS+d] != '1) doc_cnt[t*DOCS+d]++;
    if (word_cnt[t*VOCAB+w] != '1) word_cnt[t*VOCAB+w]++;
  endfunction

  function automatic void remove_tok(int t, int d, int w);
    if (topic_tot[t] != 0) topic_tot[t]--;
    if (doc_cnt[t*DOCS+d] != 0) doc_cnt[t*DOCS+d]--;
    if (word_cnt[t*VOCAB+w] != 0) word_cnt[t*VOCAB+w]--;
  endfunction

  function automatic int draw_topic(int d, int w, logic [31:0] rnd);
    int          n;
    logic [63:0] prior, a, b, den, wt, sum, u;
    logic [127:0] q;
    logic [63:0] cum [TOPICS];
    n = ntop_r;
    if (n == 0) n = 1;
    if (n > TOPICS) n = TOPICS;
    prior = 64'(vocab_r) * 64'(beta_r);
    sum = '0;
    for (int t = 0; t < n; t++) begin
      a = 64'(alpha_r) + (64'(doc_cnt[t*DOCS+d]) << 16);
      b = 64'(beta_r) + (64'(word_cnt[t*VOCAB+w]) << 16);
      den = prior + (64'(topic_tot[t]) << 16);
      if (den == 0) wt = '0;
      else begin
        q = ({64'd0, a} * {64'd0, b}) / {64'd0, den};
        wt = (q[127:64] != 0) ? '1 : q[63:0];
      end
      sum = ((64'hFFFF_FFFF_FFFF_FFFF - sum) < wt) ? '1 : sum + wt;
      cum[t] = sum;
    end
    // The draw point wraps at 64 bits exactly as the block computes it.
    u = 64'(rnd) * (sum >> 32) + ((64'(rnd) * {32'd0, sum[31:0]}) >> 32);
    for (int t = 0; t < n; t++)
      if (cum[t] > u) return t;
    return n - 1;
  endfunction

  function automatic counts_t apply_token(token_t tk);
    counts_t r;
    int t, d, w;
    t = tk.topic; d = tk.doc; w = tk.word;
    if (tk.kind == KIND_ADD) add_tok(t, d, w);
    else if (tk.kind == KIND_RESAMPLE) begin
      remove_tok(t, d, w);
      t = draw_topic(d, w, tk.rnd);
      add_tok(t, d, w);
    end
    r.topic = 6'(t);
    r.doc_cnt = doc_cnt[t*DOCS+d];
    r.word_cnt = word_cnt[t*VOCAB+w];
    r.total = topic_tot[t];
    return r;
  endfunction

  // Sender: one word in flight, a random gap after each accepted word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        expected_counts.push_back(apply_token({s_axis_tuser_i, s_axis_tdata_i[9:0],
            s_axis_tdata_i[21:10], s_axis_tdata_i[27:22], s_axis_tdata_i[59:28]}));
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_tokens.size() > 0) begin
          token_t tk;
          tk = pending_tokens.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i <= tk.kind;
          s_axis_tdata_i <= {4'd0, tk.rnd, tk.topic, tk.word, tk.doc};
          send_gap <= quiet ? 0 : $urandom_range(0, 18);
        end else s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver: checks each result word and stalls at random after it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        counts_t got, exp_c;
        int n;
        got = {m_axis_tdata_o[5:0], m_axis_tdata_o[21:6], m_axis_tdata_o[45:22],
               m_axis_tdata_o[77:46]};
        if (expected_counts.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          errors++;
        end else begin
          exp_c = expected_counts.pop_front();
          if (got.topic != exp_c.topic) begin
            $display("%0t: new_topic exp %0d got %0d", $time, exp_c.topic, got.topic);
            errors++;
          end
          if (got.doc_cnt != exp_c.doc_cnt) begin
            $display("%0t: doc_topic_count exp %0d got %0d", $time, exp_c.doc_cnt,
                     got.doc_cnt);
            errors++;
          end
          if (got.word_cnt != exp_c.word_cnt) begin
            $display("%0t: word_topic_count exp %0d got %0d", $time, exp_c.word_cnt,
                     got.word_cnt);
            errors++;
          end
          if (got.total != exp_c.total) begin
            $display("%0t: topic_total exp %0d got %0d", $time, exp_c.total, got.total);
            errors++;
          end
        end
        n = quiet ? 0 : $urandom_range(0, 18);
        recv_stall <= n;
        m_axis_tready_i <= (n == 0);
      end else if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        m_axis_tready_i <= (recv_stall == 1);
      end else m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_TOPICS: ntop_r = val[6:0];
      REG_ALPHA:  alpha_r = val[23:0];
      REG_BETA:   beta_r = val[23:0];
      default:    vocab_r = val[12:0];
    endcase
  endtask

  task automatic configure(logic [31:0] nt, logic [31:0] al, logic [31:0] be,
                           logic [31:0] vo);
    write_reg(REG_TOPICS, nt);
    write_reg(REG_ALPHA, al);
    write_reg(REG_BETA, be);
    write_reg(REG_VOCAB, vo);
  endtask

  // Waits until every word is accepted and every result has been checked.
  task automatic drain();
    while (pending_tokens.size() > 0 || s_axis_tvalid_i || expected_counts.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic void push(logic [1:0] k, int d, int w, int t, logic [31:0] r);
    token_t tk;
    tk.kind = k; tk.doc = 10'(d); tk.word = 12'(w); tk.topic = 6'(t); tk.rnd = r;
    pending_tokens.push_back(tk);
  endfunction

  // Mostly reuses a handful of documents and words so that counts build up.
  function automatic void random_tokens(int count, int resample_pct, int tmax);
    logic [1:0] k;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < resample_pct) k = KIND_RESAMPLE;
      else if (pick < resample_pct + 45) k = KIND_ADD;
      else k = ($urandom_range(0, 3) == 0) ? KIND_SPARE : KIND_QUERY;
      push(k, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 5),
           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 5),
           ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, tmax),
           $urandom());
    end
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed words at the default settings
    push(KIND_ADD, 0, 0, 0, 32'd0);
    push(KIND_ADD, 1023, 4095, 63, 32'hFFFF_FFFF);
    push(KIND_ADD, 1023, 4095, 63, 32'd0);
    push(KIND_QUERY, 1023, 4095, 63, 32'd0);
    push(KIND_SPARE, 0, 0, 0, 32'hFFFF_FFFF);
    push(KIND_QUERY, 5, 5, 5, 32'd0);
    push(KIND_ADD, 682, 2730, 42, 32'hAAAA_AAAA);
    push(KIND_ADD, 341, 1365, 21, 32'h5555_5555);
    push(KIND_RESAMPLE, 1023, 4095, 63, 32'd0);
    push(KIND_RESAMPLE, 7, 7, 7, 32'hFFFF_FFFF); // token never added: empty counts
    push(KIND_QUERY, 7, 7, 7, 32'd0);
    push(KIND_QUERY, 1023, 4095, 63, 32'd0);
    drain();
    quiet = 1'b1;
    configure(1, 0, 0, 0);               // zero priors: a denominator is zero only for an empty topic
    random_tokens(200, 35, 0);
    drain();
    quiet = 1'b0;
    configure(4, 24'hFF_FFFF, 24'hFF_FFFF, 4096);
    push(KIND_ADD, 2, 2, 3, 32'd0);
    push(KIND_RESAMPLE, 2, 2, 60, 32'hFFFF_FFFF); // topic beyond those in use
    random_tokens(250, 35, 3);
    drain();
    configure(8, 6554, 655, 1);
    random_tokens(250, 35, 7);
    drain();
    quiet = 1'b1;
    configure(3, 1, 1, 8191);
    random_tokens(250, 35, 2);
    drain();
    quiet = 1'b0;
    configure(127, 65536, 1000, 100);    // above the table size: all topics
    random_tokens(100, 8, 63);
    drain();
    configure(0, 6554, 655, 4096);       // zero topics acts as one
    random_tokens(100, 35, 0);
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: files.f
rtl/ltgs_pkg.sv
rtl/ltgs_cfg.sv
rtl/ltgs_wdiv.sv
rtl/lda_gibbs_topic_sampler.sv
verif/lda_gibbs_topic_sampler_tb.sv
